// ===== src/bpl1_pkg.sv =====
// Shared types, constants and the bin decoder for the bigram profile comparator.
package bpl1_pkg;

  // Bin layout: 28 bins for each lowercase letter
  localparam int BINS            = 728;
  localparam int BINS_PER_LETTER = 28;
  localparam int SPACE_AFTER     = 26;
  localparam int SPACE_BEFORE    = 27;
  localparam int BIN_W           = 10;
  localparam int PROF_W          = 4;
  localparam int TOTAL_W         = 32;
  localparam int DIST_W          = 18;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [7:0] CHAR_A       = 8'h61;
  localparam logic [7:0] CHAR_Z       = 8'h7A;

  // Input action codes
  localparam logic ACT_TEXT    = 1'b0;
  localparam logic ACT_COMPARE = 1'b1;

  typedef struct packed {
    logic       action;
    logic [2:0] profile;
    logic [7:0] char_code;
    logic       first_of_text;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]        reference_index;
    logic [DIST_W-1:0] distance_q16;
    logic              empty_profile;
    logic              last_result;
  } out_beat_t;

  typedef enum logic {
    CMD_INC,
    CMD_CMP
  } cmd_kind_t;

  // Work handed from front to back
  typedef struct packed {
    cmd_kind_t         kind;
    logic [PROF_W-1:0] profile;
    logic [BIN_W-1:0]  bin;
  } cmd_t;

  typedef struct packed {
    logic             hit;
    logic [BIN_W-1:0] bin;
  } bin_sel_t;

  typedef enum logic [3:0] {
    B_CLEAR,
    B_IDLE,
    B_INC_RD,
    B_INC_WR,
    B_CMP_CHK,
    B_RD_REF,
    B_RD_UNK,
    B_CAP,
    B_DIV_REF,
    B_DIV_UNK,
    B_EMIT
  } back_state_t;

  // Map a character pair to its bin, if it has one
  function automatic bin_sel_t bin_of(logic [7:0] first, logic [7:0] second);
    bin_sel_t   s;
    logic       a_let;
    logic       b_let;
    logic [4:0] la;
    logic [4:0] lb;
    a_let = (first >= CHAR_A) && (first <= CHAR_Z);
    b_let = (second >= CHAR_A) && (second <= CHAR_Z);
    la    = 5'(first - CHAR_A);
    lb    = 5'(second - CHAR_A);
    s.hit = 1'b0;
    s.bin = '0;
    if (a_let) begin
      if (b_let) begin
        s.hit = 1'b1;
        s.bin = BIN_W'(la) * BIN_W'(BINS_PER_LETTER) + BIN_W'(lb);
      end else if (second == CHAR_SPACE) begin
        s.hit = 1'b1;
        s.bin = BIN_W'(la) * BIN_W'(BINS_PER_LETTER) + BIN_W'(SPACE_AFTER);
      end
    end else if ((first == CHAR_SPACE) && b_let) begin
      s.hit = 1'b1;
      s.bin = BIN_W'(lb) * BIN_W'(BINS_PER_LETTER) + BIN_W'(SPACE_BEFORE);
    end
    return s;
  endfunction

endpackage

// ===== src/bpl1_ram.sv =====
// Generic simple dual-port RAM with registered read.
module bpl1_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4368
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bpl1_fifo.sv =====
// Short command queue between the front and the back.
module bpl1_fifo
  import bpl1_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output cmd_t pop_data,
  output logic empty
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          slots [DEPTH];
  logic [IW-1:0] wptr;
  logic [IW-1:0] rptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign pop_data = slots[rptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == IW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == IW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_data;
    end
  end

endmodule

// ===== src/bpl1_div.sv =====
// Restoring divider: floor(num * 2^FRAC_BITS / den), one quotient bit per cycle.
module bpl1_div
  import bpl1_pkg::*;
#(
  parameter int COUNT_BITS = 20,
  parameter int FRAC_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [COUNT_BITS-1:0] num,
  input  logic [TOTAL_W-1:0]    den,
  output logic                  done,
  output logic [FRAC_BITS:0]    quo
);

  localparam int DW = TOTAL_W + 1;
  localparam int CW = $clog2(FRAC_BITS + 1);

  logic               run;
  logic [CW-1:0]      cnt;
  logic [DW-1:0]      rem;
  logic [TOTAL_W-1:0] den_r;
  logic               ge;
  logic [DW-1:0]      diff;

  // One compare and subtract per step
  always_comb begin
    ge   = (rem >= {1'b0, den_r});
    diff = ge ? (rem - {1'b0, den_r}) : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
      end else if (run && (cnt == '0)) begin
        run  <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= DW'(num);
      den_r <= den;
      cnt   <= CW'(FRAC_BITS);
    end else if (run) begin
      quo <= {quo[FRAC_BITS-1:0], ge};
      rem <= {diff[DW-2:0], 1'b0};
      cnt <= cnt - 1'b1;
    end
  end

endmodule

// ===== src/bpl1_front.sv =====
// Front: accepts beats, tracks the previous character per profile, queues work.
module bpl1_front
  import bpl1_pkg::*;
#(
  parameter int NUM_PROFILES = 6
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_data,
  input  logic     clearing,
  input  logic     q_full,
  output logic     q_push,
  output cmd_t     q_data
);

  localparam int PW = $clog2(NUM_PROFILES);

  logic [7:0]    prev_char [NUM_PROFILES];
  logic [PW-1:0] pidx;
  logic          in_range;
  logic [7:0]    ch;
  logic          accept;
  bin_sel_t      sel;

  assign in_stall = clearing || q_full;
  assign accept   = in_valid && !in_stall;

  // Classify the beat
  always_comb begin
    pidx     = PW'(in_data.profile);
    in_range = (int'(in_data.profile) < NUM_PROFILES);
    ch       = (in_data.char_code == CHAR_NEWLINE) ? CHAR_SPACE : in_data.char_code;
    sel      = bin_of(prev_char[pidx], ch);
    q_data.kind    = (in_data.action == ACT_COMPARE) ? CMD_CMP : CMD_INC;
    q_data.profile = PROF_W'(pidx);
    q_data.bin     = sel.bin;
    q_push = accept && ((in_data.action == ACT_COMPARE) ||
                        (in_range && !in_data.first_of_text && sel.hit));
  end

  // Previous character per profile
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_PROFILES; i++) begin
        prev_char[i] <= '0;
      end
    end else if (accept && (in_data.action == ACT_TEXT) && in_range) begin
      prev_char[pidx] <= ch;
    end
  end

endmodule

// ===== src/bpl1_back.sv =====
// Back: clears and updates the bin counts, walks the bins for a compare.
module bpl1_back
  import bpl1_pkg::*;
#(
  parameter int NUM_PROFILES = 6,
  parameter int COUNT_BITS   = 20,
  parameter int FRAC_BITS    = 16
) (
  input  logic      clk,
  input  logic      rst,
  output logic      clearing,
  input  logic      q_empty,
  input  cmd_t      q_data,
  output logic      q_pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam int PW    = $clog2(NUM_PROFILES);
  localparam int DEPTH = NUM_PROFILES * BINS;
  localparam int AW    = $clog2(DEPTH);
  localparam int QW    = FRAC_BITS + 1;
  localparam int ACC_W = FRAC_BITS + 2;

  back_state_t state;
  back_state_t state_next;

  cmd_t               cmd;
  logic [PW-1:0]      cmd_pidx;
  logic [PW-1:0]      r;
  logic [BIN_W-1:0]   b;
  logic [AW-1:0]      clr_addr;
  logic [TOTAL_W-1:0] totals [NUM_PROFILES];
  logic [TOTAL_W-1:0] tot_sel;
  logic [PW-1:0]      tot_idx;
  logic [TOTAL_W-1:0] tr;
  logic [TOTAL_W-1:0] tu;
  logic [COUNT_BITS-1:0] cnt_ref;
  logic [COUNT_BITS-1:0] cnt_unk;
  logic [QW-1:0]      fr;
  logic [ACC_W-1:0]   acc;
  logic               empty;
  logic               sat;
  logic               out_load;
  logic               last_ref;
  logic               last_bin;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [COUNT_BITS-1:0] ram_rdata;

  logic                  div_start;
  logic [COUNT_BITS-1:0] div_num;
  logic [TOTAL_W-1:0]    div_den;
  logic                  div_done;
  logic [QW-1:0]         div_quo;

  function automatic logic [AW-1:0] slot_of(logic [PW-1:0] p, logic [BIN_W-1:0] bn);
    return AW'(p) * AW'(BINS) + AW'(bn);
  endfunction

  bpl1_ram #(
    .WIDTH(COUNT_BITS),
    .DEPTH(DEPTH)
  ) u_counts (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bpl1_div #(
    .COUNT_BITS(COUNT_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // Status terms
  always_comb begin
    cmd_pidx = PW'(cmd.profile);
    tot_idx  = (state == B_CMP_CHK) ? r : cmd_pidx;
    tot_sel  = totals[tot_idx];
    sat      = (ram_rdata == '1) || (tot_sel == '1);
    last_ref = (r == PW'(NUM_PROFILES - 2));
    last_bin = (b == BIN_W'(BINS - 1));
    out_load = (state == B_EMIT) && (!out_valid || !out_stall);
    clearing = (state == B_CLEAR);
    q_pop    = (state == B_IDLE) && !q_empty;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR:   if (clr_addr == AW'(DEPTH - 1)) state_next = B_IDLE;
      B_IDLE: begin
        if (!q_empty) begin
          state_next = (q_data.kind == CMD_CMP) ? B_CMP_CHK : B_INC_RD;
        end
      end
      B_INC_RD:  state_next = B_INC_WR;
      B_INC_WR:  state_next = B_IDLE;
      B_CMP_CHK: begin
        if ((tot_sel == '0) || (totals[NUM_PROFILES - 1] == '0)) begin
          state_next = B_EMIT;
        end else begin
          state_next = B_RD_REF;
        end
      end
      B_RD_REF:  state_next = B_RD_UNK;
      B_RD_UNK:  state_next = B_CAP;
      B_CAP:     state_next = B_DIV_REF;
      B_DIV_REF: if (div_done) state_next = B_DIV_UNK;
      B_DIV_UNK: if (div_done) state_next = last_bin ? B_EMIT : B_RD_REF;
      B_EMIT:    if (out_load) state_next = last_ref ? B_IDLE : B_CMP_CHK;
      default:   state_next = B_IDLE;
    endcase
  end

  // Memory and divider control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_of(cmd_pidx, cmd.bin);
    ram_wdata = ram_rdata + 1'b1;
    ram_raddr = slot_of(cmd_pidx, cmd.bin);
    div_start = 1'b0;
    div_num   = cnt_unk;
    div_den   = tu;
    unique case (state)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      B_INC_WR:  ram_we = !sat;
      B_RD_REF:  ram_raddr = slot_of(r, b);
      B_RD_UNK:  ram_raddr = slot_of(PW'(NUM_PROFILES - 1), b);
      B_CAP: begin
        div_start = 1'b1;
        div_num   = cnt_ref;
        div_den   = tr;
      end
      B_DIV_REF: div_start = div_done;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control counters, totals and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_PROFILES; i++) begin
        totals[i] <= '0;
      end
    end else begin
      if (state == B_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if ((state == B_INC_WR) && !sat) begin
        totals[cmd_pidx] <= tot_sel + 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Compare datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd <= q_data;
      r   <= '0;
    end
    unique case (state)
      B_CMP_CHK: begin
        tr    <= tot_sel;
        tu    <= totals[NUM_PROFILES - 1];
        acc   <= '0;
        b     <= '0;
        empty <= (tot_sel == '0) || (totals[NUM_PROFILES - 1] == '0);
      end
      B_RD_UNK:  cnt_ref <= ram_rdata;
      B_CAP:     cnt_unk <= ram_rdata;
      B_DIV_REF: if (div_done) fr <= div_quo;
      B_DIV_UNK: begin
        if (div_done) begin
          acc <= acc + ACC_W'((fr > div_quo) ? (fr - div_quo) : (div_quo - fr));
          b   <= b + 1'b1;
        end
      end
      B_EMIT:    if (out_load) r <= r + 1'b1;
      default: begin
      end
    endcase
    if (out_load) begin
      out_data.reference_index <= 3'(r);
      out_data.distance_q16    <= DIST_W'(acc);
      out_data.empty_profile   <= empty;
      out_data.last_result     <= last_ref;
    end
  end

endmodule

// ===== src/bigram_profile_l1_compare.sv =====
// Top level of the character-bigram profile comparator.
//
// Input channel (in_valid/in_stall/in_data): a text beat adds the pair it
// forms with the previous byte of the same profile to that profile's
// histogram; a compare beat asks for one distance per reference profile.
// Output channel (out_valid/out_stall/out_data): NUM_PROFILES-1 beats per
// compare, in reference order, last_result set on the final one.
// The front takes one beat a cycle into a 4-entry command queue while the
// queue has room and the count RAM is not being cleared. The back does a
// read-modify-write of the count RAM for a counted pair and walks all 728
// bins for each reference of a compare: each bin needs two count reads and
// two divisions by the shared one-bit-per-cycle divider. An empty profile
// skips the bin walk. After reset the count RAM is cleared, one entry a
// cycle, all NUM_PROFILES*728 entries (4368 by default); in_stall is high
// meanwhile. A stalled receiver holds the result register; the back waits
// on it while the front keeps filling the queue.
module bigram_profile_l1_compare
  import bpl1_pkg::*;
#(
  parameter int NUM_PROFILES = 6,
  parameter int COUNT_BITS   = 20,
  parameter int FRAC_BITS    = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic clearing;
  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  cmd_t q_out;
  logic q_empty;

  bpl1_front #(
    .NUM_PROFILES(NUM_PROFILES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .clearing(clearing),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  bpl1_fifo #(
    .DEPTH(4)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_out),
    .empty    (q_empty)
  );

  bpl1_back #(
    .NUM_PROFILES(NUM_PROFILES),
    .COUNT_BITS  (COUNT_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .q_empty  (q_empty),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

// ===== src/bpl1_checker.sv =====
// Port-level checks for the bigram comparator, bound to the top level.
module bpl1_checker
  import bpl1_pkg::*;
#(
  parameter int NUM_PROFILES = 6
) (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_beat_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // Stalled input beat holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input beat changed");

  // Stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result beat changed");

  // Nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat during reset");

  // An empty profile reports zero distance
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.empty_profile |-> out_data.distance_q16 == '0)
    else $error("empty profile with nonzero distance");

  // The final beat belongs to the last reference
  a_last_ref: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_result |->
      out_data.reference_index == 3'(NUM_PROFILES - 2))
    else $error("last beat on wrong reference");

endmodule

bind bigram_profile_l1_compare bpl1_checker #(
  .NUM_PROFILES(NUM_PROFILES)
) u_checker (
  .clk      (clk),
  .rst      (rst),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

// ===== dv/tb_bigram_profile_l1_compare.sv =====
// Testbench for the bigram profile comparator: queued stimulus, a scoreboard and random stalls.
`timescale 1ns / 1ps

module tb_bigram_profile_l1_compare;
  import bpl1_pkg::*;

  localparam int NPROF     = 6;
  localparam int UNK       = NPROF - 1;
  localparam int FRAC      = 16;
  localparam int CNT_MAX   = (1 << 20) - 1;
  localparam int CYC_LIMIT = 8000000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  bigram_profile_l1_compare u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #4 clk = ~clk;

  // Histogram shadow
  int unsigned      hist [NPROF][BINS];
  int unsigned      hist_total [NPROF];
  logic [7:0]       last_char [NPROF];

  in_beat_t  beat_q [$];
  out_beat_t dist_q [$];
  int        send_idle = 0;
  int        recv_idle = 0;
  int        hold_cnt  = 0;
  bit        arm_hold  = 0;
  int        errors    = 0;
  int        cyc       = 0;

  task automatic report(string msg);
    $display("MISMATCH @%0d: %s", cyc, msg);
    errors++;
  endtask

  // Bin index of a pair, -1 when the pair is not counted
  function automatic int pair_bin(logic [7:0] a, logic [7:0] b);
    bit al, bl;
    al = (a >= 8'h61) && (a <= 8'h7A);
    bl = (b >= 8'h61) && (b <= 8'h7A);
    if (al && bl) return (a - 8'h61) * BINS_PER_LETTER + (b - 8'h61);
    if (al && b == 8'h20) return (a - 8'h61) * BINS_PER_LETTER + SPACE_AFTER;
    if (a == 8'h20 && bl) return (b - 8'h61) * BINS_PER_LETTER + SPACE_BEFORE;
    return -1;
  endfunction

  // Update the shadow histograms, or queue the distances of a compare
  task automatic predict_beat(in_beat_t b);
    logic [7:0]      ch;
    int              bn;
    longint unsigned d, fr, fu;
    out_beat_t       o;
    if (b.action == ACT_TEXT) begin
      if (b.profile >= NPROF) return;
      ch = (b.char_code == CHAR_NEWLINE) ? CHAR_SPACE : b.char_code;
      if (!b.first_of_text) begin
        bn = pair_bin(last_char[b.profile], ch);
        if (bn >= 0 && hist[b.profile][bn] < CNT_MAX &&
            hist_total[b.profile] != 32'hFFFF_FFFF) begin
          hist[b.profile][bn]++;
          hist_total[b.profile]++;
        end
      end
      last_char[b.profile] = ch;
    end else begin
      for (int r = 0; r < UNK; r++) begin
        d = 0;
        o.empty_profile = (hist_total[r] == 0 || hist_total[UNK] == 0);
        if (!o.empty_profile)
          for (int k = 0; k < BINS; k++) begin
            fr = (longint'(hist[r][k]) << FRAC) / hist_total[r];
            fu = (longint'(hist[UNK][k]) << FRAC) / hist_total[UNK];
            d += (fr > fu) ? fr - fu : fu - fr;
          end
        o.reference_index = 3'(r);
        o.distance_q16    = DIST_W'(d);
        o.last_result     = (r == UNK - 1);
        dist_q.push_back(o);
      end
    end
  endtask

  // Driver: predict on acceptance, then offer the next beat or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_beat(in_data);
      if (!(in_valid && in_stall)) begin
        if (beat_q.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_data  <= beat_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off counter so the command queue backs up
  always @(posedge clk) begin
    if (rst) begin
      hold_cnt <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (arm_hold && out_valid) begin
      hold_cnt <= 3000;
      arm_hold <= 1'b0;
    end
  end

  // Monitor: check accepted results, drive receiver stalls
  always @(posedge clk) begin
    out_beat_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (dist_q.size() == 0) begin
          report("result beat with nothing expected");
        end else begin
          e = dist_q.pop_front();
          if (out_data.reference_index !== e.reference_index)
            report($sformatf("reference_index %0d exp %0d",
                             out_data.reference_index, e.reference_index));
          if (out_data.distance_q16 !== e.distance_q16)
            report($sformatf("ref %0d distance %0d exp %0d", e.reference_index,
                             out_data.distance_q16, e.distance_q16));
          if (out_data.empty_profile !== e.empty_profile)
            report($sformatf("ref %0d empty_profile %0b exp %0b", e.reference_index,
                             out_data.empty_profile, e.empty_profile));
          if (out_data.last_result !== e.last_result)
            report($sformatf("ref %0d last_result %0b exp %0b", e.reference_index,
                             out_data.last_result, e.last_result));
        end
      end
      if (hold_cnt > 0) begin
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYC_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_beat(bit act, int p, int c, bit f);
    in_beat_t b;
    b.action = act;
    b.profile = 3'(p);
    b.char_code = 8'(c);
    b.first_of_text = f;
    beat_q.push_back(b);
  endtask

  task automatic push_word(int p, string s);
    for (int i = 0; i < s.len(); i++) push_beat(ACT_TEXT, p, s[i], 1'b0);
  endtask

  // Mostly text-like bytes, some noise
  task automatic push_random_text();
    int r, c, p;
    r = $urandom_range(99);
    if (r < 70) c = $urandom_range(8'h7A, 8'h61);
    else if (r < 84) c = 8'h20;
    else if (r < 89) c = 8'h0A;
    else c = $urandom_range(255);
    p = ($urandom_range(99) < 5) ? $urandom_range(7, 6) : $urandom_range(UNK);
    push_beat(ACT_TEXT, p, c, $urandom_range(99) < 5);
  endtask

  task automatic push_compare();
    push_beat(ACT_COMPARE, $urandom_range(7), $urandom_range(255), $urandom_range(1));
  endtask

  task automatic drain();
    while (beat_q.size() > 0 || in_valid) @(posedge clk);
    while (dist_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    for (int p = 0; p < NPROF; p++) begin
      hist_total[p] = 0;
      last_char[p]  = '0;
      for (int k = 0; k < BINS; k++) hist[p][k] = 0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty compare, first byte after reset, bin kinds, ignored bytes
    push_compare();
    push_beat(ACT_TEXT, 0, "a", 1'b0);
    push_word(0, "bz a");
    push_beat(ACT_TEXT, 0, 8'h0A, 1'b0);
    push_word(0, "y");
    push_beat(ACT_TEXT, 0, "A", 1'b0);
    push_beat(ACT_TEXT, 0, 8'hFF, 1'b0);
    push_beat(ACT_TEXT, 0, "q", 1'b1);
    push_beat(ACT_TEXT, 6, "x", 1'b0);
    push_beat(ACT_TEXT, 7, 8'hA5, 1'b1);
    push_word(5, "ab ba");
    push_beat(ACT_TEXT, 5, 8'h0A, 1'b0);
    push_word(5, "z  ");
    push_beat(ACT_TEXT, 5, 8'h00, 1'b0);
    push_compare();
    drain();

    // Random phases: no idling, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1) ? 68 : (ph == 3) ? 27 : 0;
      recv_idle = (ph == 2) ? 68 : (ph == 3) ? 27 : 0;
      if (ph == 0) push_compare();
      for (int i = 0; i < 90; i++) push_random_text();
      push_compare();
      drain();
    end

    // Pressure: hold the receiver off while text keeps coming
    send_idle = 0;
    recv_idle = 0;
    arm_hold  = 1;
    push_compare();
    for (int i = 0; i < 60; i++) push_random_text();
    push_compare();
    drain();

    if (errors == 0 && dist_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/bpl1_pkg.sv
src/bpl1_ram.sv
src/bpl1_fifo.sv
src/bpl1_div.sv
src/bpl1_front.sv
src/bpl1_back.sv
src/bigram_profile_l1_compare.sv
src/bpl1_checker.sv
dv/tb_bigram_profile_l1_compare.sv
